/* sv/icpc_pkg.sv */
// Shared types and constants of the ICMP probe reply classifier.
package icpc_pkg;

    typedef enum logic [1:0] {
        CLS_NOT_OURS = 2'd0,
        CLS_ROUTER   = 2'd1,
        CLS_DEST     = 2'd2
    } t_reply_class;

    typedef enum logic {
        CFG_SOURCE_PORT        = 1'b0,
        CFG_EXPECTED_DEST_PORT = 1'b1
    } t_cfg_index;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] SOURCE_PORT_RESET = 16'd0;
    localparam logic [15:0] DEST_PORT_RESET   = 16'd33436;

    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_TTL_EXPIRED   = 8'd0;
    localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] PROTO_UDP          = 8'd17;

    // Byte offsets from the start of the ICMP message
    localparam logic [15:0] OFS_CODE       = 16'd1;
    localparam logic [15:0] OFS_INNER_IHL  = 16'd8;
    localparam logic [15:0] OFS_INNER_PROT = 16'd17;
    localparam logic [15:0] ICMP_MIN_BYTES = 16'd36;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic         valid;
        t_reply_class cls;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

/* sv/icpc_front.sv */
// Front end: byte position tracking, header field capture and reply classification.
module icpc_front #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [icpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [icpc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    input  logic [7:0]                        i_byte,
    input  logic                              i_last,
    input  icpc_pkg::t_fifo_stat              i_stat,
    output logic                              o_ready,
    output icpc_pkg::t_push                   o_push
);

    localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);

    logic [15:0] r_src_cfg, r_dst_cfg;
    logic [15:0] r_pos, n_pos;
    logic [5:0]  r_h1, n_h1;
    logic [5:0]  r_ih, n_ih;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_prot, n_prot;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [3:0]  r_seen, n_seen;

    logic        accept;
    logic        in_range;
    logic [15:0] h1_ext;
    logic [15:0] udp_base;
    logic [15:0] total;
    icpc_pkg::t_reply_class cls;

    assign o_ready = !i_stat.full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cfg <= icpc_pkg::SOURCE_PORT_RESET;
            r_dst_cfg <= icpc_pkg::DEST_PORT_RESET;
        end else if (i_cfg_we) begin
            case (icpc_pkg::t_cfg_index'(i_cfg_addr))
                icpc_pkg::CFG_SOURCE_PORT:        r_src_cfg <= i_cfg_wdata;
                icpc_pkg::CFG_EXPECTED_DEST_PORT: r_dst_cfg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_range = r_pos < MAX_POS;
        n_h1     = r_h1;
        n_type   = r_type;
        n_code   = r_code;
        n_ih     = r_ih;
        n_prot   = r_prot;
        n_sport  = r_sport;
        n_dport  = r_dport;
        n_seen   = r_seen;

        if (in_range && r_pos == 16'd0) begin
            n_h1 = {i_byte[3:0], 2'b00};
        end
        h1_ext = {10'd0, n_h1};
        if (in_range && r_pos == h1_ext) begin
            n_type = i_byte;
        end
        if (in_range && r_pos == h1_ext + icpc_pkg::OFS_CODE) begin
            n_code    = i_byte;
            n_seen[0] = 1'b1;
        end
        if (in_range && r_pos == h1_ext + icpc_pkg::OFS_INNER_IHL) begin
            n_ih = {i_byte[3:0], 2'b00};
        end
        if (in_range && r_pos == h1_ext + icpc_pkg::OFS_INNER_PROT) begin
            n_prot    = i_byte;
            n_seen[1] = 1'b1;
        end
        // Embedded UDP header starts after the ICMP header and the inner IP header
        udp_base = h1_ext + icpc_pkg::OFS_INNER_IHL + {10'd0, n_ih};
        if (in_range && r_pos == udp_base) begin
            n_sport[15:8] = i_byte;
        end
        if (in_range && r_pos == udp_base + 16'd1) begin
            n_sport[7:0] = i_byte;
            n_seen[2]    = 1'b1;
        end
        if (in_range && r_pos == udp_base + 16'd2) begin
            n_dport[15:8] = i_byte;
        end
        if (in_range && r_pos == udp_base + 16'd3) begin
            n_dport[7:0] = i_byte;
            n_seen[3]    = 1'b1;
        end

        n_pos = (r_pos != icpc_pkg::POS_MAX) ? r_pos + 16'd1 : r_pos;
        total = (n_pos > MAX_POS) ? MAX_POS : n_pos;

        cls = icpc_pkg::CLS_NOT_OURS;
        if (total >= h1_ext + icpc_pkg::ICMP_MIN_BYTES && n_seen == 4'hF &&
            n_prot == icpc_pkg::PROTO_UDP && n_sport == r_src_cfg &&
            n_dport == r_dst_cfg) begin
            if (n_type == icpc_pkg::TYPE_TIME_EXCEEDED &&
                n_code == icpc_pkg::CODE_TTL_EXPIRED) begin
                cls = icpc_pkg::CLS_ROUTER;
            end else if (n_type == icpc_pkg::TYPE_DEST_UNREACH &&
                         n_code == icpc_pkg::CODE_PORT_UNREACH) begin
                cls = icpc_pkg::CLS_DEST;
            end
        end

        o_push.valid = accept && i_last;
        o_push.cls   = cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_pos   <= '0;
            r_h1    <= '0;
            r_ih    <= '0;
            r_type  <= '0;
            r_code  <= '0;
            r_prot  <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_seen  <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_h1    <= n_h1;
            r_ih    <= n_ih;
            r_type  <= n_type;
            r_code  <= n_code;
            r_prot  <= n_prot;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_seen  <= n_seen;
        end
    end

endmodule

/* sv/icpc_fifo.sv */
// Short class queue between the front end and the output stage.
module icpc_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  icpc_pkg::t_push        i_push,
    input  logic                   i_pop,
    output icpc_pkg::t_fifo_stat   o_stat,
    output icpc_pkg::t_reply_class o_head
);

    icpc_pkg::t_reply_class r_mem [icpc_pkg::FIFO_DEPTH];
    logic [icpc_pkg::FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [icpc_pkg::FIFO_PTR_W:0]   r_cnt;
    logic                            do_pop;

    assign o_stat.full  = r_cnt == (icpc_pkg::FIFO_PTR_W+1)'(icpc_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_head       = r_mem[r_rd];
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* sv/icpc_back.sv */
// Output stage: registered result word toward the downstream sink.
module icpc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  icpc_pkg::t_fifo_stat   i_stat,
    input  icpc_pkg::t_reply_class i_head,
    input  logic                   i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [7:0]             o_data
);

    logic                   r_valid;
    icpc_pkg::t_reply_class r_cls;

    // Refill when the held word is gone or leaves this cycle
    assign o_pop   = !i_stat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {6'd0, r_cls};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cls <= i_head;
        end
    end

endmodule

/* sv/icmp_probe_reply_classifier_top.sv */
// Top level of the ICMP probe reply classifier.
//
//  channel   | direction | handshake        | contents
//  s_axis    | in        | tvalid / tready  | tdata[7:0] data_byte, tlast last_byte
//  m_axis    | out       | tvalid / tready  | tdata[1:0] reply_class, [7:2] zero
//  cfg       | in        | we only          | addr 0 source_port, 1 expected_dest_port
//
// One byte is taken every cycle while the class queue has room.
// A tlast byte's class is queued, then sent on m_axis from the output register.
// The queue holds two words plus one in the output register, so a stall on
// m_axis stops s_axis only once all three are full.
// Reset is synchronous; no clearing pass, the block is ready right after it.
module icmp_probe_reply_classifier_top #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [icpc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [icpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,  // [7:0] data_byte
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata   // [1:0] reply_class
);

    icpc_pkg::t_push        push;
    icpc_pkg::t_fifo_stat   stat;
    icpc_pkg::t_reply_class head;
    logic                   pop;

    icpc_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_stat      (stat),
        .o_ready     (o_s_axis_tready),
        .o_push      (push)
    );

    icpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (stat),
        .o_head  (head)
    );

    icpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .i_head  (head),
        .i_ready (i_m_axis_tready),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

endmodule

/* sv/icpc_checker.sv */
// Port-level checks of the ICMP probe reply classifier, bound to the top level.
module icpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word dropped or changed under stall");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[1:0] != 2'd3 && o_m_axis_tdata[7:2] == 6'd0)
        else $error("result word carries an undefined class");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not idle after reset");

    // Without a final byte nothing new can reach an empty output
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && !(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast)
            ##1 !o_m_axis_tvalid && !$past(i_s_axis_tvalid && o_s_axis_tready &&
            i_s_axis_tlast, 1) |=> !o_m_axis_tvalid || $past(o_s_axis_tready, 2))
        else $error("result word without a final byte");

endmodule

bind icmp_probe_reply_classifier_top icpc_checker u_icpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
